[rtl/ufdp_pkg.sv]
// shared types, constants and codes of the ultrasonic frame distance parser
package ufdp_pkg;

    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int DIST_W      = 13;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = 32;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'hFF;
    localparam logic [BYTE_W-1:0] MARKER_BYTE  = 8'hAA;
    localparam logic [BYTE_W-1:0] MARKER_SUM   = 8'd53;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [RAW_W-1:0] DIV10_RECIP = 16'hCCCD;
    localparam int               DIV10_SHIFT = 19;

    localparam logic [DIST_W-1:0] STOP_DISTANCE_RESET = 13'd5;
    localparam logic [RAW_W-1:0]  MAX_RANGE_RESET     = 16'd4500;

    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_DISTANCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RANGE     = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID        = 2'd0,
        STATUS_OUT_OF_RANGE = 2'd1,
        STATUS_BAD_SUM      = 2'd2,
        STATUS_NO_HEADER    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_HIGH   = 2'd1,
        POS_LOW    = 2'd2,
        POS_SUM    = 2'd3
    } pos_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        status_t          status;
    } entry_t;

endpackage

[rtl/ufdp_if.sv]
// valid/ready channels for received bytes and distance results
interface ufdp_byte_if;
    logic                       valid;
    logic                       ready;
    logic [ufdp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufdp_result_if;
    logic                          valid;
    logic                          ready;
    logic [ufdp_pkg::DIST_W-1:0]   distance_cm;
    logic [ufdp_pkg::STATUS_W-1:0] frame_status;
    logic                          collision;

    modport source (output valid, output distance_cm, output frame_status,
                    output collision, input ready);
    modport sink   (input valid, input distance_cm, input frame_status,
                    input collision, output ready);
endinterface

[rtl/ufdp_front.sv]
// front end: frame position tracking and classification of received bytes
module ufdp_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    input  logic [ufdp_pkg::BYTE_W-1:0]    rx_byte,
    output logic                           ready,
    input  logic [ufdp_pkg::RAW_W-1:0]     max_range_raw,
    input  logic                           queue_full,
    output logic                           push,
    output ufdp_pkg::entry_t               push_entry
);

    ufdp_pkg::pos_t               pos_reg;
    ufdp_pkg::pos_t               pos_next;
    logic [ufdp_pkg::BYTE_W-1:0]  high_reg;
    logic [ufdp_pkg::BYTE_W-1:0]  low_reg;
    logic [ufdp_pkg::BYTE_W-1:0]  sum;
    logic                         accept;

    assign ready  = !queue_full;
    assign accept = valid && ready;
    assign sum    = ufdp_pkg::FRAME_HEADER + high_reg + low_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            case (pos_reg)
                ufdp_pkg::POS_HEADER:
                begin
                    if (rx_byte == ufdp_pkg::FRAME_HEADER)
                    begin
                        pos_next = ufdp_pkg::POS_HIGH;
                    end
                end
                ufdp_pkg::POS_HIGH: pos_next = ufdp_pkg::POS_LOW;
                ufdp_pkg::POS_LOW:  pos_next = ufdp_pkg::POS_SUM;
                ufdp_pkg::POS_SUM:  pos_next = ufdp_pkg::POS_HEADER;
                default:            pos_next = ufdp_pkg::POS_HEADER;
            endcase
        end
    end

    always_comb
    begin
        push              = 1'b0;
        push_entry.raw    = '0;
        push_entry.status = ufdp_pkg::STATUS_NO_HEADER;
        case (pos_reg)
            ufdp_pkg::POS_HEADER:
            begin
                push = accept && (rx_byte != ufdp_pkg::FRAME_HEADER);
            end
            ufdp_pkg::POS_SUM:
            begin
                push = accept;
                if (high_reg == ufdp_pkg::MARKER_BYTE && low_reg == ufdp_pkg::MARKER_BYTE
                    && rx_byte == ufdp_pkg::MARKER_SUM)
                begin
                    push_entry.raw    = max_range_raw;
                    push_entry.status = ufdp_pkg::STATUS_OUT_OF_RANGE;
                end
                else if (sum == rx_byte)
                begin
                    push_entry.raw    = {high_reg, low_reg};
                    push_entry.status = ufdp_pkg::STATUS_VALID;
                end
                else
                begin
                    push_entry.status = ufdp_pkg::STATUS_BAD_SUM;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= ufdp_pkg::POS_HEADER;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg == ufdp_pkg::POS_HIGH)
        begin
            high_reg <= rx_byte;
        end
        if (accept && pos_reg == ufdp_pkg::POS_LOW)
        begin
            low_reg <= rx_byte;
        end
    end

    // a checksum byte always closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos_reg == ufdp_pkg::POS_SUM |=> pos_reg == ufdp_pkg::POS_HEADER)
        else $error("frame not closed after checksum byte");

    // a result leaves the front only for a stray byte or a checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept && (pos_reg == ufdp_pkg::POS_SUM || pos_reg == ufdp_pkg::POS_HEADER))
        else $error("result pushed outside header or checksum position");

endmodule

[rtl/ufdp_queue.sv]
// short queue of classified frames between front and back
module ufdp_queue
#(
    parameter int DEPTH = ufdp_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ufdp_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output ufdp_pkg::entry_t  pop_entry
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    ufdp_pkg::entry_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

[rtl/ufdp_back.sv]
// back end: divide by ten, collision compare and output register
module ufdp_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           queue_not_empty,
    input  ufdp_pkg::entry_t               queue_entry,
    output logic                           pop,
    input  logic [ufdp_pkg::DIST_W-1:0]    stop_distance,
    output logic                           valid,
    input  logic                           ready,
    output logic [ufdp_pkg::DIST_W-1:0]    distance_cm,
    output logic [ufdp_pkg::STATUS_W-1:0]  frame_status,
    output logic                           collision
);

    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic [ufdp_pkg::DIST_W-1:0]   a_quot_reg;
    ufdp_pkg::status_t             a_status_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [ufdp_pkg::DIST_W-1:0]   out_dist_reg;
    ufdp_pkg::status_t             out_status_reg;
    logic                          out_coll_reg;
    logic                          a_ready;
    logic                          b_ready;
    logic                          b_load;
    logic [ufdp_pkg::PROD_W-1:0]   product;

    assign b_ready = !out_valid_reg || ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = queue_not_empty && a_ready;
    assign b_load  = a_valid_reg && b_ready;
    assign product = ufdp_pkg::PROD_W'(queue_entry.raw) * ufdp_pkg::PROD_W'(ufdp_pkg::DIV10_RECIP);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (pop)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_ready)
        begin
            a_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (b_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_quot_reg   <= product[ufdp_pkg::DIV10_SHIFT +: ufdp_pkg::DIST_W];
            a_status_reg <= queue_entry.status;
        end
        if (b_load)
        begin
            out_dist_reg   <= a_quot_reg;
            out_status_reg <= a_status_reg;
            out_coll_reg   <= (stop_distance >= a_quot_reg);
        end
    end

    assign valid        = out_valid_reg;
    assign distance_cm  = out_dist_reg;
    assign frame_status = out_status_reg;
    assign collision    = out_coll_reg;

    // stray bytes and bad sums carry zero distance, hence always collide
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && (out_status_reg == ufdp_pkg::STATUS_NO_HEADER
                  || out_status_reg == ufdp_pkg::STATUS_BAD_SUM)
        |-> distance_cm == '0 && collision)
        else $error("zero-distance result without collision");

    assert property (@(posedge clk) disable iff (!rst_n)
        b_load |=> valid && distance_cm == $past(a_quot_reg))
        else $error("output register missed a quotient");

endmodule

[rtl/ultrasonic_frame_distance_parser.sv]
// top level: configuration registers and the front, queue and back of the parser
// a result is held in a queue slot, then in the quotient and output registers
// throughput: one byte per cycle while the queue is not full; the queue lets
//   the front keep taking bytes while the back waits on a stalled output
// reset: position back to header search, queue and pipeline empty, registers to
//   stop_distance 5 and max_range_raw 4500; no clearing pass
module ultrasonic_frame_distance_parser
#(
    parameter int QUEUE_DEPTH = ufdp_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    ufdp_byte_if.sink                         byte_in,
    ufdp_result_if.source                     result_out,
    input  logic                              cfg_we,
    input  logic [ufdp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ufdp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [ufdp_pkg::DIST_W-1:0] stop_distance_reg;
    logic [ufdp_pkg::RAW_W-1:0]  max_range_reg;
    logic                        queue_full;
    logic                        queue_not_empty;
    logic                        push;
    logic                        pop;
    ufdp_pkg::entry_t            push_entry;
    ufdp_pkg::entry_t            pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_distance_reg <= ufdp_pkg::STOP_DISTANCE_RESET;
            max_range_reg     <= ufdp_pkg::MAX_RANGE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ufdp_pkg::CFG_STOP_DISTANCE: stop_distance_reg <= cfg_data[ufdp_pkg::DIST_W-1:0];
                ufdp_pkg::CFG_MAX_RANGE:     max_range_reg     <= cfg_data[ufdp_pkg::RAW_W-1:0];
                default:                     ;
            endcase
        end
    end

    ufdp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid         (byte_in.valid),
        .rx_byte       (byte_in.rx_byte),
        .ready         (byte_in.ready),
        .max_range_raw (max_range_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    ufdp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .pop_entry  (pop_entry)
    );

    ufdp_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_entry     (pop_entry),
        .pop             (pop),
        .stop_distance   (stop_distance_reg),
        .valid           (result_out.valid),
        .ready           (result_out.ready),
        .distance_cm     (result_out.distance_cm),
        .frame_status    (result_out.frame_status),
        .collision       (result_out.collision)
    );

endmodule
